// ===== hw/rtl/mbrx_pkg.sv =====
// Shared types and constants for the mailbox byte receive FIFO.
`timescale 1ns / 1ps
package mbrx_pkg;

    localparam int WORD_W     = 26;
    localparam int DATA_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 2;
    localparam int MARGIN_W   = 7;
    localparam int COUNT_LSB  = 24;

    localparam logic                KIND_MAILBOX = 1'b0;
    localparam logic                KIND_READ    = 1'b1;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 7'd3;

    typedef struct packed {
        logic              is_read;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic              fifo_empty;
        logic              clear_mailbox;
        logic              rx_irq_enable;
        logic              overflow;
    } t_result;

endpackage

// ===== hw/rtl/mbrx_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mbrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mbrx_front.sv =====
// Command front end: decodes input words and queues them for the back end.
`timescale 1ns / 1ps
module mbrx_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_kind,
    input  logic [25:0]            i_mailbox_word,
    output logic                   o_cmd_valid,
    output mbrx_pkg::t_cmd         o_cmd,
    input  logic                   i_pop
);
    import mbrx_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_push;
    t_cmd       w_cmd;

    assign o_busy      = (r_count == 2'd2);
    assign w_push      = i_start && !o_busy;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        w_cmd.is_read = (i_kind == KIND_READ);
        w_cmd.count   = i_mailbox_word[COUNT_LSB +: CNT_W];
        w_cmd.data    = i_mailbox_word[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_cmd;
                r_wr      <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            unique case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/mbrx_back.sv =====
// Back end: executes queued commands against the byte store, builds results.
`timescale 1ns / 1ps
module mbrx_back #(
    parameter int FIFO_DEPTH = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  mbrx_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    input  logic [mbrx_pkg::MARGIN_W-1:0]   i_resume_margin,
    output logic                            o_done,
    output mbrx_pkg::t_result               o_result
);
    import mbrx_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int MW = (CW > MARGIN_W) ? CW : MARGIN_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(FIFO_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_PUSH, S_FINISH} t_state;

    t_state            r_state;
    logic              r_is_read;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_data;
    logic              r_ovf;
    logic              r_got;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     r_wr_ptr;
    logic [CW-1:0]     r_fill;
    logic              r_pending;
    logic              r_irq;
    logic              r_done;
    t_result           r_result;

    logic              w_room;
    logic              w_met;
    logic [MW-1:0]     w_free;
    logic [BYTE_W-1:0] w_wbyte;
    logic [BYTE_W-1:0] w_rdata;

    assign w_room = (r_fill < DEPTH_C);
    assign w_free = MW'(DEPTH_C - r_fill);
    assign w_met  = (w_free > MW'(i_resume_margin));
    assign o_pop  = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_wbyte = r_data[7:0];
            2'd1:    w_wbyte = r_data[15:8];
            default: w_wbyte = r_data[23:16];
        endcase
    end

    mbrx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_PUSH) && w_room),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_wbyte),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_pending <= 1'b0;
            r_irq     <= 1'b1;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_is_read <= i_cmd.is_read;
                        r_cnt     <= i_cmd.count;
                        r_data    <= i_cmd.data;
                        r_idx     <= '0;
                        r_ovf     <= 1'b0;
                        r_got     <= 1'b0;
                        if (i_cmd.is_read) begin
                            if (r_fill != '0) begin
                                r_got    <= 1'b1;
                                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
                                r_fill   <= r_fill - 1'b1;
                            end
                            r_state <= S_FINISH;
                        end else if (i_cmd.count == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_PUSH: begin
                    if (w_room) begin
                        r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
                        r_fill   <= r_fill + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CNT_W'(r_cnt - 1'b1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_done                <= 1'b1;
                    r_result.byte_valid   <= r_got;
                    r_result.byte_value   <= r_got ? w_rdata : '0;
                    r_result.fifo_empty   <= (r_fill == '0);
                    r_result.overflow     <= r_ovf;
                    r_result.clear_mailbox <= 1'b0;
                    r_result.rx_irq_enable <= r_irq;
                    if (r_is_read) begin
                        if (r_pending && w_met) begin
                            r_result.clear_mailbox <= 1'b1;
                            r_result.rx_irq_enable <= 1'b1;
                            r_pending <= 1'b0;
                            r_irq     <= 1'b1;
                        end
                    end else if (w_met) begin
                        r_result.clear_mailbox <= 1'b1;
                    end else begin
                        r_result.rx_irq_enable <= 1'b0;
                        r_pending <= 1'b1;
                        r_irq     <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/mailbox_byte_receive_fifo.sv =====
// Top level of the mailbox byte receive FIFO.
`timescale 1ns / 1ps
// Commands enter on start while busy is low and sit in a two-word queue;
// busy rises only when that queue is full. Each command produces exactly one
// result, shown for one cycle with o_done; the receiver cannot stall it. The
// back end handles one command at a time, taking it from the queue when
// idle: a read passes through S_IDLE and S_FINISH, a mailbox word through
// S_IDLE, S_PUSH once per byte (one store write per byte that fits, through
// the single write port) and S_FINISH, and the result appears in the cycle
// after S_FINISH. The byte store is not cleared at reset and needs no
// clearing pass. The resume margin may be written at any time o_cfg_ready is
// high, while no command is outstanding.
module mailbox_byte_receive_fifo #(
    parameter int FIFO_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [25:0] i_mailbox_word,
    output logic        o_done,
    output logic        o_byte_valid,
    output logic [7:0]  o_byte_value,
    output logic        o_fifo_empty,
    output logic        o_clear_mailbox,
    output logic        o_rx_irq_enable,
    output logic        o_overflow,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    import mbrx_pkg::*;

    logic [MARGIN_W-1:0] r_resume_margin;
    logic                w_cmd_valid;
    t_cmd                w_cmd;
    logic                w_pop;
    t_result             w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resume_margin <= MARGIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_resume_margin <= i_cfg_data;
        end
    end

    mbrx_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_kind         (i_kind),
        .i_mailbox_word (i_mailbox_word),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_pop          (w_pop)
    );

    mbrx_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_pop           (w_pop),
        .i_resume_margin (r_resume_margin),
        .o_done          (o_done),
        .o_result        (w_result)
    );

    assign o_byte_valid    = w_result.byte_valid;
    assign o_byte_value    = w_result.byte_value;
    assign o_fifo_empty    = w_result.fifo_empty;
    assign o_clear_mailbox = w_result.clear_mailbox;
    assign o_rx_irq_enable = w_result.rx_irq_enable;
    assign o_overflow      = w_result.overflow;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_read_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_byte_valid |-> !o_overflow)
        else $error("overflow flagged on a read word");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_byte_valid |-> (o_byte_value == 8'd0))
        else $error("byte value nonzero without a popped byte");

    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_valid)
        else $error("back end popped an empty command queue");

endmodule
